>>> design/assert_macros.svh
// Assertion macros used by the traversal block's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

>>> design/gdbt_pkg.sv
// Types and constants shared by the graph traversal block.
`default_nettype none
package gdbt_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = VTX_W + 1;
    localparam int FIELD_W      = 6;
    localparam int ACTION_W     = 2;

    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RUN   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd3;

    localparam logic PASS_DEPTH   = 1'b0;
    localparam logic PASS_BREADTH = 1'b1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [FIELD_W-1:0]  edge_from;
        logic [FIELD_W-1:0]  edge_to;
        logic [FIELD_W-1:0]  start_vertex;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] visited_vertex;
        logic               pass_kind;
        logic               error;
        logic               last;
    } out_item_t;

    // Command to the adjacency store; rows are vertex numbers minus one.
    typedef struct packed {
        logic             clear;
        logic             add;
        logic [VTX_W-1:0] row_a;
        logic [VTX_W-1:0] row_b;
    } adj_cmd_t;

    // Access to the stack and queue RAM.
    typedef struct packed {
        logic             wr_en;
        logic [VTX_W-1:0] wr_addr;
        logic [VTX_W-1:0] wr_data;
        logic             rd_en;
        logic [VTX_W-1:0] rd_addr;
    } mem_req_t;

    // Result of the neighbour search.
    typedef struct packed {
        logic             found;
        logic [VTX_W-1:0] idx;
    } pick_t;

endpackage
`default_nettype wire

>>> design/gdbt_adj.sv
// Adjacency bit matrix with whole-matrix clear and symmetric edge insert.
`default_nettype none
module gdbt_adj
    import gdbt_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire adj_cmd_t                cmd,
    input  wire logic [VTX_W-1:0]        rd_idx,
    output logic      [MAX_VERTICES-1:0] rd_row
);

    logic [MAX_VERTICES-1:0] rows_reg [MAX_VERTICES];

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
                rows_reg[i] <= '0;
            end
        end else if (cmd.add) begin
            // Each row is written at most once; a self loop sets its diagonal bit.
            for (int i = 0; i < MAX_VERTICES; i++) begin
                if (VTX_W'(i) == cmd.row_a) begin
                    rows_reg[i] <= rows_reg[i] | (MAX_VERTICES'(1) << cmd.row_b);
                end else if (VTX_W'(i) == cmd.row_b) begin
                    rows_reg[i] <= rows_reg[i] | (MAX_VERTICES'(1) << cmd.row_a);
                end
            end
        end
    end

    assign rd_row = rows_reg[rd_idx];

endmodule
`default_nettype wire

>>> design/gdbt_mem.sv
// Stack and queue RAM with one write port, one read port and registered read data.
`default_nettype none
module gdbt_mem
    import gdbt_pkg::*;
(
    input  wire logic             aclk,
    input  wire mem_req_t         req,
    output logic      [VTX_W-1:0] rd_data
);

    logic [VTX_W-1:0] ram_reg [MAX_VERTICES];
    logic [VTX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            ram_reg[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= ram_reg[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> design/gdbt_pick.sv
// Shared neighbour search: masks a row and finds its lowest unvisited vertex.
`default_nettype none
module gdbt_pick
    import gdbt_pkg::*;
(
    input  wire logic [MAX_VERTICES-1:0] row,
    input  wire logic [MAX_VERTICES-1:0] live_mask,
    input  wire logic [MAX_VERTICES-1:0] visited,
    output pick_t                        result
);

    logic [MAX_VERTICES-1:0] cand;

    always_comb begin
        cand = row & live_mask & ~visited;
        result.found = |cand;
        result.idx   = '0;
        // Scanning downwards leaves the lowest set bit as the winner.
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (cand[i]) begin
                result.idx = VTX_W'(i);
            end
        end
    end

endmodule
`default_nettype wire

>>> design/graph_dfs_bfs_traversal.sv
// Top level of the graph traversal block: sequencer, registers and output stage.
//
//   Channel  Ports                        Direction  Carries
//   input    s_valid s_ready s_data       in         clear, add-edge or run command
//   result   m_valid m_ready m_data       out        one visited vertex or an error per transfer
//   config   cfg_wr_en cfg_wr_data        in         vertex_count, no read-back
//
// Clear, add-edge and unused commands complete in the cycle of their transfer.
// A run makes a depth-first pass and then a breadth-first pass, which queues each
// neighbour before it reports the vertex; the stack/queue RAM with its registered read
// port and the shared neighbour search set how long a run takes.
// A result stall holds the sequencer only when it must load a result; runs take no input.
// Sync reset clears the adjacency matrix, state, pointers, visited set and output valid.
`default_nettype none
`include "assert_macros.svh"
module graph_dfs_bfs_traversal
    import gdbt_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire in_item_t           s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output out_item_t               m_data,
    input  wire logic               cfg_wr_en,
    input  wire logic [FIELD_W-1:0] cfg_wr_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_D_READ,
        ST_D_EXP,
        ST_B_INIT,
        ST_B_READ,
        ST_B_EXP
    } state_t;

    state_t                  state_reg,   state_next;
    logic [FIELD_W-1:0]      vcount_reg;
    logic [CNT_W-1:0]        sp_reg,      sp_next;
    logic [CNT_W-1:0]        head_reg,    head_next;
    logic [CNT_W-1:0]        tail_reg,    tail_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [MAX_VERTICES-1:0] mask_reg,    mask_next;
    logic [VTX_W-1:0]        start_reg,   start_next;
    logic                    bad_reg,     bad_next;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg,  m_data_next;

    logic [FIELD_W-1:0]      live_n;
    logic                    out_free;
    logic                    out_load;
    out_item_t               out_item;
    adj_cmd_t                adj_cmd;
    mem_req_t                mem_req;
    logic [VTX_W-1:0]        mem_rd_data;
    logic [MAX_VERTICES-1:0] adj_row;
    pick_t                   pick;

    function automatic logic vertex_ok(input logic [FIELD_W-1:0] v,
                                       input logic [FIELD_W-1:0] n);
        return (v != '0) && (v <= n);
    endfunction

    gdbt_adj u_adj (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (adj_cmd),
        .rd_idx  (mem_rd_data),
        .rd_row  (adj_row)
    );

    gdbt_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    gdbt_pick u_pick (
        .row       (adj_row),
        .live_mask (mask_reg),
        .visited   (visited_reg),
        .result    (pick)
    );

    assign live_n   = (vcount_reg > FIELD_W'(MAX_VERTICES)) ? FIELD_W'(MAX_VERTICES)
                                                             : vcount_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        sp_next      = sp_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        visited_next = visited_reg;
        mask_next    = mask_reg;
        start_next   = start_reg;
        bad_next     = bad_reg;
        s_ready      = 1'b0;
        adj_cmd      = '0;
        mem_req      = '0;
        out_load     = 1'b0;
        out_item     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (s_data.action)
                        ACT_CLEAR: begin
                            adj_cmd.clear = 1'b1;
                        end
                        ACT_ADD: begin
                            if (vertex_ok(s_data.edge_from, live_n) &&
                                vertex_ok(s_data.edge_to, live_n)) begin
                                adj_cmd.add   = 1'b1;
                                adj_cmd.row_a = VTX_W'(s_data.edge_from - FIELD_W'(1));
                                adj_cmd.row_b = VTX_W'(s_data.edge_to - FIELD_W'(1));
                            end
                        end
                        ACT_RUN: begin
                            start_next = VTX_W'(s_data.start_vertex - FIELD_W'(1));
                            bad_next   = !vertex_ok(s_data.start_vertex, live_n);
                            for (int i = 0; i < MAX_VERTICES; i++) begin
                                mask_next[i] = FIELD_W'(i) < live_n;
                            end
                            state_next = ST_START;
                        end
                        ACT_NONE: begin
                        end
                    endcase
                end
            end
            ST_START: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (bad_reg) begin
                        out_item.pass_kind = PASS_DEPTH;
                        out_item.error     = 1'b1;
                        out_item.last      = 1'b1;
                        state_next         = ST_IDLE;
                    end else begin
                        out_item.visited_vertex = FIELD_W'(start_reg) + FIELD_W'(1);
                        out_item.pass_kind      = PASS_DEPTH;
                        mem_req.wr_en           = 1'b1;
                        mem_req.wr_addr         = '0;
                        mem_req.wr_data         = start_reg;
                        sp_next                 = CNT_W'(1);
                        visited_next            = MAX_VERTICES'(1) << start_reg;
                        state_next              = ST_D_READ;
                    end
                end
            end
            ST_D_READ: begin
                if (sp_reg == '0) begin
                    state_next = ST_B_INIT;
                end else begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = VTX_W'(sp_reg - CNT_W'(1));
                    state_next      = ST_D_EXP;
                end
            end
            ST_D_EXP: begin
                // The registered read data is the vertex on top of the stack.
                if (!pick.found) begin
                    sp_next    = sp_reg - CNT_W'(1);
                    state_next = ST_D_READ;
                end else if (out_free) begin
                    out_load                = 1'b1;
                    out_item.visited_vertex = FIELD_W'(pick.idx) + FIELD_W'(1);
                    out_item.pass_kind      = PASS_DEPTH;
                    visited_next            = visited_reg | (MAX_VERTICES'(1) << pick.idx);
                    if (sp_reg < CNT_W'(MAX_VERTICES)) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = VTX_W'(sp_reg);
                        mem_req.wr_data = pick.idx;
                        sp_next         = sp_reg + CNT_W'(1);
                    end
                    state_next = ST_D_READ;
                end
            end
            ST_B_INIT: begin
                visited_next    = MAX_VERTICES'(1) << start_reg;
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = '0;
                mem_req.wr_data = start_reg;
                head_next       = '0;
                tail_next       = CNT_W'(1);
                state_next      = ST_B_READ;
            end
            ST_B_READ: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = VTX_W'(head_reg);
                head_next       = head_reg + CNT_W'(1);
                state_next      = ST_B_EXP;
            end
            ST_B_EXP: begin
                // Neighbours are queued one a cycle; the vertex itself is reported
                // once they are all queued, so that the final one can carry last.
                if (pick.found) begin
                    visited_next = visited_reg | (MAX_VERTICES'(1) << pick.idx);
                    if (tail_reg < CNT_W'(MAX_VERTICES)) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = VTX_W'(tail_reg);
                        mem_req.wr_data = pick.idx;
                        tail_next       = tail_reg + CNT_W'(1);
                    end
                end else if (out_free) begin
                    out_load                = 1'b1;
                    out_item.visited_vertex = FIELD_W'(mem_rd_data) + FIELD_W'(1);
                    out_item.pass_kind      = PASS_BREADTH;
                    out_item.last           = head_reg == tail_reg;
                    state_next              = (head_reg == tail_reg) ? ST_IDLE : ST_B_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = out_item;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            vcount_reg  <= FIELD_W'(MAX_VERTICES);
            sp_reg      <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            visited_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            visited_reg <= visited_next;
            mask_reg    <= mask_next;
            start_reg   <= start_next;
            bad_reg     <= bad_next;
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
            if (cfg_wr_en) begin
                vcount_reg <= cfg_wr_data;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_NEVER(a_stack_bound, aclk, aresetn, sp_reg > CNT_W'(MAX_VERTICES), "stack overrun")
    `ASSERT_CLK(a_queue_order, aclk, aresetn, head_reg <= tail_reg, "queue head passed tail")
    `ASSERT_NEVER(a_pop_before_exp, aclk, aresetn, (state_reg == ST_B_EXP) && (head_reg == '0), "queue expand without a pop")
    `ASSERT_CLK(a_last_ends_run, aclk, aresetn, (out_load && out_item.last) |=> (state_reg == ST_IDLE), "run continued after its final result")

endmodule
`default_nettype wire

>>> bench/graph_dfs_bfs_traversal_tb.sv
// Self-checking testbench for the graph traversal block: directed table, then random bursts.
`timescale 1ns / 100ps
module graph_dfs_bfs_traversal_tb
    import gdbt_pkg::*;
();

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam out_item_t ERR_RESULT = '{visited_vertex: '0, pass_kind: PASS_DEPTH,
                                         error: 1'b1, last: 1'b1};

    typedef struct packed {
        logic                 set_count;
        logic [FIELD_W-1:0]   count_value;
        in_item_t             cmd;
        logic [1:0]           n_typed;
        out_item_t [1:0]      typed;
    } directed_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    in_item_t           s_data;
    logic               m_valid;
    logic               m_ready;
    out_item_t          m_data;
    logic               cfg_wr_en;
    logic [FIELD_W-1:0] cfg_wr_data;

    // Shadow copy of the graph and the vertex count register.
    logic [31:0]        model_adj [MAX_VERTICES];
    logic [FIELD_W-1:0] model_count;

    out_item_t     traversal_out [$];
    out_item_t     pending_visits [$];
    directed_row_t directed_rows [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    graph_dfs_bfs_traversal i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("graph_dfs_bfs_traversal: mismatch");
            $finish;
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    function automatic out_item_t visit(input int unsigned v, input logic kind, input logic fin);
        out_item_t r;
        r.visited_vertex = FIELD_W'(v);
        r.pass_kind      = kind;
        r.error          = 1'b0;
        r.last           = fin;
        return r;
    endfunction

    function automatic in_item_t make_item(input logic [ACTION_W-1:0] act, input int unsigned a,
                                           input int unsigned b, input int unsigned s);
        in_item_t r;
        r.action       = act;
        r.edge_from    = FIELD_W'(a);
        r.edge_to      = FIELD_W'(b);
        r.start_vertex = FIELD_W'(s);
        return r;
    endfunction

    function automatic int unsigned lowest_set(input logic [31:0] bits);
        int unsigned pos;
        pos = 0;
        while (pos < 31 && bits[pos] == 1'b0)
            pos++;
        return pos;
    endfunction

    // Updates the shadow graph and fills traversal_out with the visits a command causes.
    function automatic void predict_traversal(input in_item_t cmd);
        int unsigned n, a, b, s, sp, head, tail, top, cur, nx, i;
        logic [31:0] mask, marks, cand;
        logic [4:0]  stk  [MAX_VERTICES];
        logic [4:0]  fifo [MAX_VERTICES];
        traversal_out.delete();
        n    = (model_count > MAX_VERTICES) ? MAX_VERTICES : model_count;
        mask = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
        a    = cmd.edge_from;
        b    = cmd.edge_to;
        s    = cmd.start_vertex;
        case (cmd.action)
            ACT_CLEAR: begin
                for (i = 0; i < MAX_VERTICES; i++)
                    model_adj[i] = '0;
            end
            ACT_ADD: begin
                if (a >= 1 && a <= n && b >= 1 && b <= n) begin
                    model_adj[a-1][b-1] = 1'b1;
                    model_adj[b-1][a-1] = 1'b1;
                end
            end
            ACT_RUN: begin
                if (s < 1 || s > n) begin
                    traversal_out = {traversal_out, ERR_RESULT};
                end else begin
                    marks  = 32'd1 << (s - 1);
                    stk[0] = 5'(s - 1);
                    sp     = 1;
                    traversal_out = {traversal_out, visit(s, PASS_DEPTH, 1'b0)};
                    while (sp > 0) begin
                        top  = stk[sp-1];
                        cand = model_adj[top] & mask & ~marks;
                        if (cand == '0) begin
                            sp--;
                        end else begin
                            nx = lowest_set(cand);
                            marks[nx] = 1'b1;
                            traversal_out = {traversal_out, visit(nx + 1, PASS_DEPTH, 1'b0)};
                            if (sp < MAX_VERTICES) begin
                                stk[sp] = 5'(nx);
                                sp++;
                            end
                        end
                    end
                    // The final breadth-first visit is the one that leaves the queue empty.
                    marks   = 32'd1 << (s - 1);
                    fifo[0] = 5'(s - 1);
                    head    = 0;
                    tail    = 1;
                    while (head < tail) begin
                        cur  = fifo[head];
                        head++;
                        cand = model_adj[cur] & mask & ~marks;
                        while (cand != '0) begin
                            nx = lowest_set(cand);
                            cand[nx]  = 1'b0;
                            marks[nx] = 1'b1;
                            if (tail < MAX_VERTICES) begin
                                fifo[tail] = 5'(nx);
                                tail++;
                            end
                        end
                        traversal_out = {traversal_out,
                                         visit(cur + 1, PASS_BREADTH, head == tail)};
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input out_item_t want, input out_item_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: expected vertex %0d kind %0b err %0b last %0b, got %0d %0b %0b %0b",
                     what, want.visited_vertex, want.pass_kind, want.error, want.last,
                     got.visited_vertex, got.pass_kind, got.error, got.last);
    endtask

    always @(posedge aclk) begin : check_visits
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_visits.size() == 0) begin
                note_mismatch("result with nothing pending", '0, m_data);
            end else begin
                want = pending_visits.pop_front();
                if (m_data.visited_vertex !== want.visited_vertex ||
                    m_data.pass_kind !== want.pass_kind ||
                    m_data.error !== want.error ||
                    m_data.last !== want.last)
                    note_mismatch("visit differs", want, m_data);
            end
        end
    end

    // Presents one command; returns at the falling edge after its transfer, valid still high.
    task automatic drive_item(input in_item_t cmd);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = cmd;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic issue(input in_item_t cmd);
        predict_traversal(cmd);
        pending_visits = {pending_visits, traversal_out};
        drive_item(cmd);
    endtask

    task automatic wait_quiet();
        s_valid = 1'b0;
        while (pending_visits.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_count(input logic [FIELD_W-1:0] value);
        wait_quiet();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        model_count = value;
    endtask

    task automatic add_row(input logic set_count, input int unsigned count_value,
                           input in_item_t cmd, input int unsigned n_typed,
                           input out_item_t t0, input out_item_t t1);
        directed_row_t r;
        r.set_count   = set_count;
        r.count_value = FIELD_W'(count_value);
        r.cmd         = cmd;
        r.n_typed     = 2'(n_typed);
        r.typed[0]    = t0;
        r.typed[1]    = t1;
        directed_rows = {directed_rows, r};
    endtask

    function automatic int unsigned pick_vertex(input int unsigned n);
        if (n == 0 || $urandom_range(99) < 10)
            return $urandom_range(63);
        return $urandom_range(n, 1);
    endfunction

    // Mostly clear / add edges / run bursts with random content, the rest raw noise.
    task automatic random_phase(input int budget);
        int issued, n, k;
        issued = 0;
        n = (model_count > MAX_VERTICES) ? MAX_VERTICES : model_count;
        while (issued < budget) begin
            if ($urandom_range(99) < 70) begin
                if ($urandom_range(1) == 1) begin
                    issue(make_item(ACT_CLEAR, $urandom_range(63), $urandom_range(63),
                                    $urandom_range(63)));
                    issued++;
                end
                k = $urandom_range(10);
                repeat (k) begin
                    issue(make_item(ACT_ADD, pick_vertex(n), pick_vertex(n),
                                    $urandom_range(63)));
                    issued++;
                end
                repeat ($urandom_range(2, 1)) begin
                    issue(make_item(ACT_RUN, $urandom_range(63), $urandom_range(63),
                                    pick_vertex(n)));
                    issued++;
                end
            end else begin
                issue(make_item(ACTION_W'($urandom_range(3)), $urandom_range(63),
                                $urandom_range(63), $urandom_range(63)));
                issued++;
            end
        end
    endtask

    initial begin : main_seq
        int phase;
        int phase_counts [8];
        out_item_t none;
        directed_row_t r;
        none        = '0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        model_count = FIELD_W'(MAX_VERTICES);
        for (phase = 0; phase < MAX_VERTICES; phase++)
            model_adj[phase] = '0;

        // Directed table: typed results only where they are plain to see.
        add_row(0, 0, make_item(ACT_RUN, 0, 0, 0), 1, ERR_RESULT, none);
        add_row(0, 0, make_item(ACT_RUN, 0, 0, 33), 1, ERR_RESULT, none);
        add_row(0, 0, make_item(ACT_RUN, 0, 0, 32), 2,
                visit(32, PASS_DEPTH, 1'b0), visit(32, PASS_BREADTH, 1'b1));
        add_row(0, 0, make_item(ACT_RUN, 63, 63, 63), 1, ERR_RESULT, none);
        add_row(0, 0, make_item(ACT_ADD, 1, 2, 0), 0, none, none);
        add_row(0, 0, make_item(ACT_ADD, 2, 3, 0), 0, none, none);
        add_row(0, 0, make_item(ACT_ADD, 1, 4, 0), 0, none, none);
        add_row(0, 0, make_item(ACT_ADD, 4, 5, 0), 0, none, none);
        add_row(0, 0, make_item(ACT_ADD, 3, 5, 0), 0, none, none);
        add_row(0, 0, make_item(ACT_ADD, 32, 1, 0), 0, none, none);
        add_row(0, 0, make_item(ACT_ADD, 0, 5, 0), 0, none, none);
        add_row(0, 0, make_item(ACT_ADD, 5, 33, 0), 0, none, none);
        add_row(0, 0, make_item(ACT_ADD, 7, 7, 0), 0, none, none);
        add_row(0, 0, make_item(ACT_ADD, 63, 63, 63), 0, none, none);
        add_row(0, 0, make_item(ACT_NONE, 63, 63, 63), 0, none, none);
        add_row(0, 0, make_item(ACT_RUN, 0, 0, 1), 0, none, none);
        add_row(0, 0, make_item(ACT_RUN, 0, 0, 7), 0, none, none);
        add_row(1, 4, make_item(ACT_RUN, 0, 0, 1), 0, none, none);
        add_row(0, 0, make_item(ACT_RUN, 0, 0, 5), 1, ERR_RESULT, none);
        add_row(1, 0, make_item(ACT_RUN, 0, 0, 1), 1, ERR_RESULT, none);
        add_row(0, 0, make_item(ACT_ADD, 1, 2, 0), 0, none, none);
        add_row(1, 63, make_item(ACT_RUN, 0, 0, 32), 0, none, none);
        add_row(0, 0, make_item(ACT_CLEAR, 63, 63, 63), 0, none, none);
        add_row(0, 0, make_item(ACT_RUN, 0, 0, 1), 2,
                visit(1, PASS_DEPTH, 1'b0), visit(1, PASS_BREADTH, 1'b1));
        add_row(1, 1, make_item(ACT_RUN, 0, 0, 1), 2,
                visit(1, PASS_DEPTH, 1'b0), visit(1, PASS_BREADTH, 1'b1));
        add_row(0, 0, make_item(ACT_RUN, 0, 0, 2), 1, ERR_RESULT, none);

        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            if (r.set_count)
                write_count(r.count_value);
            predict_traversal(r.cmd);
            if (r.n_typed == 0) begin
                pending_visits = {pending_visits, traversal_out};
            end else begin
                for (int j = 0; j < r.n_typed; j++)
                    pending_visits = {pending_visits, r.typed[j]};
            end
            drive_item(r.cmd);
        end

        phase_counts = '{32, 7, 63, 1, 0, 32, 20, 32};
        phase_counts[6] = $urandom_range(31, 2);
        for (phase = 0; phase < 8; phase++) begin
            // Each count change waits for every pending visit: a full pause on the sender.
            write_count(FIELD_W'(phase_counts[phase]));
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 51; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 51; end
                default: begin src_idle_pct = 35; sink_stall_pct = 35; end
            endcase
            random_phase(23);
        end

        s_valid = 1'b0;
        while (pending_visits.size() != 0)
            @(negedge aclk);
        repeat (4 * SETTLE_CYCLES) @(negedge aclk);
        if (mismatch_count == 0)
            $display("graph_dfs_bfs_traversal: match");
        else
            $display("graph_dfs_bfs_traversal: mismatch");
        $finish;
    end

endmodule
